// File: hdl/bsa_pkg.sv
// Shared types, constants and helper functions for the bitmap slot allocator.
`default_nettype none

package bsa_pkg;

   // Bitmap geometry
   localparam int MAX_SLOTS = 1024;
   localparam int ID_W      = $clog2(MAX_SLOTS);
   localparam int WORD_W    = 32;
   localparam int BIT_AW    = $clog2(WORD_W);
   localparam int WORD_CNT  = MAX_SLOTS / WORD_W;
   localparam int WORD_AW   = $clog2(WORD_CNT);

   // Field widths
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int BASE_W   = 32;
   localparam int SIZE_W   = 16;
   localparam int COUNT_W  = 11;
   localparam int PROD_W   = ID_W + SIZE_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(MAX_SLOTS);

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MARK   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT  = 2'd2;

   localparam logic [BASE_W-1:0]  RECORD_BASE_RST = '0;
   localparam logic [SIZE_W-1:0]  RECORD_SIZE_RST = 16'd128;
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RST  = 11'd1024;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   slot_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     result_id;
      logic [STATUS_W-1:0] status;
      logic                is_free;
      logic [BASE_W-1:0]   record_addr;
   } rsp_type;

   typedef struct packed {
      logic [BASE_W-1:0]  record_base;
      logic [SIZE_W-1:0]  record_size;
      logic [COUNT_W-1:0] slot_count;
   } cfg_type;

   // Bitmap access from the sequencer
   typedef struct packed {
      logic               rd_en;
      logic [WORD_AW-1:0] rd_addr;
      logic               wr_en;
      logic [WORD_AW-1:0] wr_addr;
      logic [WORD_W-1:0]  wr_data;
   } map_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   rd_data;
      logic [WORD_CNT-1:0] full;
   } map_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   // Lowest set bit of a word summary vector
   function automatic logic [WORD_AW-1:0] lowest_word(input logic [WORD_CNT-1:0] v);
      logic [WORD_AW-1:0] idx;
      idx = '0;
      for (int i = WORD_CNT - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = WORD_AW'(i);
         end
      end
      return idx;
   endfunction

   // Lowest set bit within one bitmap word
   function automatic logic [BIT_AW-1:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [BIT_AW-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_AW'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: hdl/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: registers, output stage, core and bitmap.
`default_nettype none

// Each item passes through acceptance (bitmap word read issued, word search
// over the full-word summary, id times record size), execute (the registered
// bitmap read returns; lowest free bit, modify and write back), and hand-off to
// the output register. The next item is taken once the previous result has
// moved into the output register, so a new item is not taken before the last
// one is through. The bitmap is 32 words of 32 bits with a
// valid and a full flag per word in flip-flops, so reset clears it at once and
// there is no clearing pass. Configuration is written through csr_wr_en,
// csr_index and csr_wdata; index 0 record_base, 1 record_size, 2 slot_count.
module bitmap_slot_allocator (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  bsa_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output bsa_pkg::rsp_type                   rsp_data,
   input  wire                                csr_wr_en,
   input  wire [bsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [bsa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bsa_pkg::*;

   cfg_type     cfg_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        out_ready;
   logic        res_valid;
   rsp_type     res_data;
   map_req_type map_req;
   map_rsp_type map_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.record_base <= RECORD_BASE_RST;
         cfg_ff.record_size <= RECORD_SIZE_RST;
         cfg_ff.slot_count  <= SLOT_COUNT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RECORD_BASE: cfg_ff.record_base <= csr_wdata[BASE_W-1:0];
            CSR_RECORD_SIZE: cfg_ff.record_size <= csr_wdata[SIZE_W-1:0];
            CSR_SLOT_COUNT:  cfg_ff.slot_count  <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Output register: load when empty or being drained
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bsa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .out_ready (out_ready),
      .res_data  (res_data),
      .map_req   (map_req),
      .map_rsp   (map_rsp)
   );

   bsa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .map_rsp (map_rsp)
   );

endmodule

`default_nettype wire

// File: hdl/bsa_map.sv
// Used/free bitmap storage: word memory with per-word valid and full flags.
`default_nettype none

module bsa_map (
   input  wire                  clock,
   input  wire                  reset,
   input  bsa_pkg::map_req_type map_req,
   output bsa_pkg::map_rsp_type map_rsp
);
   import bsa_pkg::*;

   logic [WORD_W-1:0]   mem [WORD_CNT];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                rd_valid_ff;
   logic [WORD_CNT-1:0] valid_ff;
   logic [WORD_CNT-1:0] full_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= mem[map_req.rd_addr];
      end
   end

   // A word never written since reset reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         full_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (map_req.wr_en) begin
            valid_ff[map_req.wr_addr] <= 1'b1;
            full_ff[map_req.wr_addr]  <= &map_req.wr_data;
         end
         if (map_req.rd_en) begin
            rd_valid_ff <= valid_ff[map_req.rd_addr];
         end
      end
   end

   assign map_rsp.rd_data = rd_valid_ff ? rd_data_ff : '0;
   assign map_rsp.full    = full_ff;

endmodule

`default_nettype wire

// File: hdl/bsa_core.sv
// Request sequencer: word search, bitmap read-modify-write and result forming.
`default_nettype none

module bsa_core (
   input  wire                  clock,
   input  wire                  reset,
   input  bsa_pkg::cfg_type     cfg,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  bsa_pkg::req_type     req_data,
   output logic                 res_valid,
   input  wire                  out_ready,
   output bsa_pkg::rsp_type     res_data,
   output bsa_pkg::map_req_type map_req,
   input  bsa_pkg::map_rsp_type map_rsp
);
   import bsa_pkg::*;

   state_type state_ff, state_in;

   logic [KIND_W-1:0]  kind_ff;
   logic [ID_W-1:0]    id_ff;
   logic [WORD_AW-1:0] word_ff, word_in;
   logic               wfound_ff, wfound_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   rsp_type            res_ff, res_in;

   logic                accept;
   logic [COUNT_W-1:0]  eff_count;
   logic [COUNT_W-1:0]  count_round;
   logic [WORD_AW:0]    word_lim;
   logic [WORD_CNT-1:0] eligible;
   logic [WORD_CNT-1:0] cand;

   logic [WORD_W-1:0] cur;
   logic [BIT_AW-1:0] bit_sel;
   logic [WORD_W-1:0] bit_mask;
   logic [WORD_W-1:0] zero_vec;
   logic [BIT_AW-1:0] zbit;
   logic [ID_W-1:0]   alloc_slot;
   logic              alloc_ok;
   logic              in_range;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   rsp_type           exec_res;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Clamp count and find the lowest word that is not full below it
   assign eff_count   = (cfg.slot_count > SLOT_LIMIT) ? SLOT_LIMIT : cfg.slot_count;
   assign count_round = eff_count + COUNT_W'(WORD_W - 1);
   assign word_lim    = count_round[COUNT_W-1:BIT_AW];

   always_comb begin
      for (int w = 0; w < WORD_CNT; w++) begin
         eligible[w] = ((WORD_AW + 1)'(w) < word_lim);
      end
   end

   assign cand      = eligible & ~map_rsp.full;
   assign wfound_in = |cand;
   assign word_in   = (req_data.kind == KIND_ALLOC) ? lowest_word(cand)
                                                    : req_data.slot_id[ID_W-1:BIT_AW];
   assign prod_in   = PROD_W'(req_data.slot_id) * PROD_W'(cfg.record_size);

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_data.kind;
         id_ff     <= req_data.slot_id;
         word_ff   <= word_in;
         wfound_ff <= wfound_in;
         prod_ff   <= prod_in;
      end
      res_ff <= res_in;
   end

   // Execute on the word read back from the bitmap
   assign cur        = map_rsp.rd_data;
   assign bit_sel    = id_ff[BIT_AW-1:0];
   assign bit_mask   = WORD_W'(1) << bit_sel;
   assign zero_vec   = ~cur;
   assign zbit       = lowest_bit(zero_vec);
   assign alloc_slot = {word_ff, zbit};
   assign alloc_ok   = wfound_ff && (|zero_vec) && ({1'b0, alloc_slot} < eff_count);
   assign in_range   = ({1'b0, id_ff} < eff_count) && (kind_ff <= KIND_LOCATE);

   always_comb begin
      exec_res.result_id   = id_ff;
      exec_res.status      = STATUS_OK;
      exec_res.is_free     = 1'b0;
      exec_res.record_addr = '0;
      wr_en                = 1'b0;
      wr_data              = cur;
      priority if (kind_ff == KIND_ALLOC) begin
         if (alloc_ok) begin
            exec_res.result_id = alloc_slot;
            wr_en              = 1'b1;
            wr_data            = cur | (WORD_W'(1) << zbit);
         end else begin
            exec_res.result_id = '0;
            exec_res.status    = STATUS_NO_FREE;
         end
      end else if (!in_range) begin
         exec_res.status = STATUS_RANGE;
      end else if (kind_ff == KIND_MARK) begin
         wr_en   = 1'b1;
         wr_data = cur | bit_mask;
      end else if (kind_ff == KIND_FREE) begin
         wr_en   = 1'b1;
         wr_data = cur & ~bit_mask;
      end else if (kind_ff == KIND_QUERY) begin
         exec_res.is_free = ~cur[bit_sel];
      end else begin
         if (!cur[bit_sel]) begin
            exec_res.status = STATUS_NOT_USED;
         end else begin
            exec_res.record_addr = cfg.record_base + BASE_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_HOLD;
         ST_HOLD: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin : fsm_outputs
      req_stall       = 1'b1;
      res_valid       = 1'b0;
      res_in          = res_ff;
      map_req.rd_en   = 1'b0;
      map_req.rd_addr = word_in;
      map_req.wr_en   = 1'b0;
      map_req.wr_addr = word_ff;
      map_req.wr_data = wr_data;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            map_req.rd_en = req_valid;
         end
         ST_EXEC: begin
            map_req.wr_en = wr_en;
            res_in        = exec_res;
         end
         ST_HOLD: res_valid = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   assign res_data = res_ff;

   // The bitmap is only written while executing an item
   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      map_req.wr_en |-> state_ff == ST_EXEC)
      else $error("bitmap written outside execute");

   // Read data is consumed in the cycle after the read was issued
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $past(map_req.rd_en))
      else $error("execute without a matching bitmap read");

   // A write changes at most one bit of the word
   a_single_bit: assert property (@(posedge clock) disable iff (reset)
      map_req.wr_en |-> $countones(map_req.wr_data ^ cur) <= 1)
      else $error("bitmap write changed more than one slot");

endmodule

`default_nettype wire

// File: verif/tb_bitmap_slot_allocator.sv
// Self-checking testbench for the bitmap slot allocator: directed and random requests.
`default_nettype none

module tb_bitmap_slot_allocator;
   import bsa_pkg::*;

   // Kinds past locate carry no operation and must be rejected
   localparam logic [KIND_W-1:0] KIND_RESERVED_LO = KIND_LOCATE + 3'd1;
   localparam logic [KIND_W-1:0] KIND_RESERVED_HI = '1;

   // Tracks the slot bitmap and registers, and holds the results still owed by the block
   class slot_scoreboard;
      bit [MAX_SLOTS-1:0] used_slots;
      logic [BASE_W-1:0]  base;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] count;
      rsp_type            owed_results[$];
      int unsigned        failures;

      function new();
         used_slots = '0;
         base       = RECORD_BASE_RST;
         size       = RECORD_SIZE_RST;
         count      = SLOT_COUNT_RST;
         failures   = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_RECORD_BASE: base = val;
            CSR_RECORD_SIZE: size = val[SIZE_W-1:0];
            CSR_SLOT_COUNT:  count = val[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned live_slots();
         return (count > MAX_SLOTS) ? MAX_SLOTS : int'(count);
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction

      function void note_request(input req_type r);
         rsp_type     e;
         int unsigned lim;
         bit          found;
         e     = '0;
         e.result_id = r.slot_id;
         lim   = live_slots();
         found = 1'b0;
         if (r.kind == KIND_ALLOC) begin
            e.result_id = '0;
            for (int i = 0; i < lim; i++) begin
               if (!found && !used_slots[i]) begin
                  found         = 1'b1;
                  used_slots[i] = 1'b1;
                  e.result_id   = ID_W'(i);
               end
            end
            e.status = found ? STATUS_OK : STATUS_NO_FREE;
         end else if (r.kind > KIND_LOCATE || r.slot_id >= lim) begin
            e.status = STATUS_RANGE;
         end else begin
            case (r.kind)
               KIND_MARK:  used_slots[r.slot_id] = 1'b1;
               KIND_FREE:  used_slots[r.slot_id] = 1'b0;
               KIND_QUERY: e.is_free = !used_slots[r.slot_id];
               KIND_LOCATE: begin
                  if (!used_slots[r.slot_id]) begin
                     e.status = STATUS_NOT_USED;
                  end else begin
                     e.record_addr = base + BASE_W'(r.slot_id) * BASE_W'(size);
                  end
               end
               default: ;
            endcase
         end
         owed_results.push_back(e);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (owed_results.size() == 0) begin
            $error("result with no request outstanding: %p", got);
            failures++;
            return;
         end
         e = owed_results.pop_front();
         if (got.result_id !== e.result_id) begin
            $error("result_id: expected %0d, actual %0d", e.result_id, got.result_id);
            failures++;
         end
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            failures++;
         end
         if (got.is_free !== e.is_free) begin
            $error("is_free: expected %0d, actual %0d", e.is_free, got.is_free);
            failures++;
         end
         if (got.record_addr !== e.record_addr) begin
            $error("record_addr: expected 0x%08h, actual 0x%08h", e.record_addr, got.record_addr);
            failures++;
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit             calm = 1'b0;
   slot_scoreboard sb   = new();

   bitmap_slot_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure, off during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 11);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
   end

   task automatic send_item(input req_type r);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic issue(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id);
      req_type r;
      r.kind    = k;
      r.slot_id = id;
      send_item(r);
   endtask

   // Hold the sender until every owed result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic configure(input logic [BASE_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [COUNT_W-1:0] count);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RECORD_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_RECORD_SIZE;
      csr_wdata <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_index <= CSR_SLOT_COUNT;
      csr_wdata <= CSR_DATA_W'(count);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(CSR_RECORD_BASE, base);
      sb.set_reg(CSR_RECORD_SIZE, CSR_DATA_W'(size));
      sb.set_reg(CSR_SLOT_COUNT, CSR_DATA_W'(count));
   endtask

   function automatic logic [KIND_W-1:0] pick_kind();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return KIND_ALLOC;
      if (roll < 45) return KIND_MARK;
      if (roll < 65) return KIND_FREE;
      if (roll < 80) return KIND_QUERY;
      if (roll < 95) return KIND_LOCATE;
      return KIND_W'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
   endfunction

   // Mostly live slots, some at the count boundary, some anywhere in the id space
   function automatic logic [ID_W-1:0] pick_slot();
      int unsigned lim;
      int unsigned roll;
      lim  = sb.live_slots();
      roll = $urandom_range(0, 99);
      if (lim == 0 || roll < 12) return ID_W'($urandom_range(0, MAX_SLOTS - 1));
      if (roll < 22) return ID_W'(lim - 1 + $urandom_range(0, 1));
      return ID_W'($urandom_range(0, lim - 1));
   endfunction

   task automatic run_phase(input logic [BASE_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [COUNT_W-1:0] count, input int n_items,
                            input bit quiet);
      configure(base, size, count);
      calm = quiet;
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 99) == 0) wait_idle();
         issue(pick_kind(), pick_slot());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset configuration, full id range
      issue(KIND_ALLOC, '1);
      issue(KIND_ALLOC, '0);
      issue(KIND_QUERY, '0);
      issue(KIND_QUERY, '1);
      issue(KIND_LOCATE, '0);
      issue(KIND_LOCATE, '1);
      issue(KIND_MARK, '1);
      issue(KIND_LOCATE, '1);
      issue(KIND_MARK, '1);
      issue(KIND_FREE, 10'd1);
      issue(KIND_FREE, 10'd1);
      issue(KIND_QUERY, 10'd1);
      issue(KIND_RESERVED_LO, '1);
      issue(KIND_RESERVED_LO + 3'd1, '0);
      issue(KIND_RESERVED_HI, 10'd512);
      issue(KIND_ALLOC, 10'd700);
      issue(KIND_LOCATE, 10'd1);
      issue(KIND_FREE, '1);
      issue(KIND_LOCATE, '1);

      run_phase('1, '1, '1, 150, 1'b0);
      run_phase('0, '0, '0, 20, 1'b0);
      run_phase($urandom(), 16'd1, 11'd1, 80, 1'b0);
      run_phase($urandom(), SIZE_W'($urandom()), 11'd8, 180, 1'b1);
      run_phase('0, '1, 11'd40, 200, 1'b0);
      run_phase($urandom(), '0, SLOT_LIMIT, 150, 1'b0);
      run_phase($urandom(), SIZE_W'($urandom()), 11'd20, 200, 1'b0);
      run_phase('1, '1, SLOT_LIMIT - 11'd1, 120, 1'b0);
      run_phase($urandom(), SIZE_W'($urandom()), 11'd3, 100, 1'b0);
      run_phase($urandom(), SIZE_W'($urandom()), COUNT_W'($urandom_range(1, 64)), 150, 1'b0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
